FILE: src/rmth_pkg.sv
//------------------------------------------------------------------------------
// rmth_pkg
// Shared types and constants for the two-heap running median.
//------------------------------------------------------------------------------
`default_nettype none
package rmth_pkg;
  // sample width; the median field carries one extra bit for the doubled value
  localparam int SAMPLE_BITS = 32;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          sample_missing;
    logic                          restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] median_doubled;
    logic                        median_valid;
    logic [10:0]                 stored_count;
    logic                        overflow;
  } out_item_t;
endpackage
`default_nettype wire

FILE: src/rmth_ram.sv
//------------------------------------------------------------------------------
// rmth_ram
// Simple dual-port RAM: one write and one registered read per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/running_median_two_heaps.sv
//------------------------------------------------------------------------------
// running_median_two_heaps
// Running median over a max-heap (lower half) and a min-heap (upper half).
//------------------------------------------------------------------------------
// Usage:
//   Input channel in/in_valid/in_ready carries one sample per item; output
//   channel out/out_valid/out_ready returns one result per item: twice the
//   median, a valid flag, the stored count and a drop flag.
//   Each item is handled by a small sequencer over a shared compare function
//   and one RAM per heap (one read and one write a cycle). A decide state
//   picks the path, a sift-down level issues the left read, issues the right
//   read and picks a child, a sift-up level issues the parent read and
//   compares the parent, and a final pass rereads both tops and loads the
//   result register. An item needs at most one sift-down and one sift-up; a
//   missing or dropped sample goes straight to rereading the tops. The next
//   item is accepted in the cycle after the result is loaded, so the block
//   takes no new item until the last one has its result loaded.
//   The result register parts the two sides: a new item is accepted while a
//   result waits, and a stalled receiver holds the block only at its last
//   step, until the waiting result leaves.
//   Reset empties both heaps (counts to zero); heap RAM is not cleared.
//------------------------------------------------------------------------------
`default_nettype none
module running_median_two_heaps #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rmth_pkg::in_item_t  in,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output rmth_pkg::out_item_t      out,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import rmth_pkg::*;

  localparam int LD = (CAPACITY + 1) / 2;
  localparam int UD = (CAPACITY / 2 > 0) ? CAPACITY / 2 : 1;
  localparam int DEP = (LD > UD) ? LD : UD;
  localparam int AW = (DEP > 1) ? $clog2(DEP) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SB = SAMPLE_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;  // decide path, tops known
  localparam logic [3:0] S_UPRD  = 4'd2;  // sift-up: issue parent read
  localparam logic [3:0] S_UPCMP = 4'd3;  // sift-up: compare parent
  localparam logic [3:0] S_DNL   = 4'd4;  // sift-down: issue left read
  localparam logic [3:0] S_DNR   = 4'd5;  // sift-down: left data, issue right
  localparam logic [3:0] S_DNCMP = 4'd6;  // sift-down: pick child
  localparam logic [3:0] S_TOPRD = 4'd7;  // reread both tops
  localparam logic [3:0] S_TOPW  = 4'd8;  // wait for top data
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [CW-1:0] lcnt, ucnt;
  logic signed [SB-1:0] samp, ltop, utop, val, pend;
  logic heap;        // 0 lower (max), 1 upper (min)
  logic pend_up;     // push pend after current sift-down
  logic pend_heap;
  logic [AW:0] pos, best, n;
  logic signed [SB-1:0] bestv;
  logic dropped;
  logic out_load;

  // RAM ports
  logic          l_we, u_we;
  logic [AW-1:0] waddr, raddr;
  logic [SB-1:0] wdata, l_rd, u_rd;

  rmth_ram #(.WIDTH(SB), .DEPTH(DEP)) u_lower (
    .clk(clk), .we(l_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(l_rd));
  rmth_ram #(.WIDTH(SB), .DEPTH(DEP)) u_upper (
    .clk(clk), .we(u_we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(u_rd));

  logic signed [SB-1:0] rd;
  assign rd = heap ? $signed(u_rd) : $signed(l_rd);

  // shared compare: a ranks above b in current heap
  function automatic logic above(input logic h, input logic signed [SB-1:0] a,
                                 input logic signed [SB-1:0] b);
    above = h ? (a < b) : (a > b);
  endfunction

  logic [AW:0] par, lch;
  assign par = (pos - 1'b1) >> 1;
  assign lch = {pos[AW-1:0], 1'b1};

  // right child index one bit wider so it cannot wrap past the count
  logic [AW+1:0] rch;
  logic rwin;
  logic [AW:0] dn_next;
  logic signed [SB-1:0] dn_val;
  assign rch     = {1'b0, lch} + 1'b1;
  assign rwin    = (rch < {1'b0, n}) && above(heap, rd, bestv);
  assign dn_next = rwin ? rch[AW:0] : best;
  assign dn_val  = rwin ? rd : bestv;

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    l_we  = 1'b0;
    u_we  = 1'b0;
    waddr = pos[AW-1:0];
    wdata = val;
    raddr = par[AW-1:0];
    case (state)
      S_UPRD:  raddr = par[AW-1:0];
      S_UPCMP: begin
        if (pos != '0 && above(heap, val, rd)) begin
          wdata = rd;
        end
        if (heap) u_we = 1'b1; else l_we = 1'b1;
      end
      S_DNL:   raddr = lch[AW-1:0];
      S_DNR:   raddr = rch[AW-1:0];
      S_DNCMP: begin
        // winning child moves up, or the held value lands here
        wdata = dn_val;
        if (heap) u_we = 1'b1; else l_we = 1'b1;
      end
      S_TOPRD: raddr = '0;
      default: ;
    endcase
  end

  // result register: load when free or leaving, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lcnt      <= '0;
      ucnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            samp    <= in.sample[SB-1:0];
            dropped <= 1'b0;
            pend_up <= 1'b0;
            if (in.restart) begin
              lcnt <= '0;
              ucnt <= '0;
            end
            if (in.sample_missing) begin
              state <= S_TOPRD;
            end else if (!in.restart && (32'(lcnt) + 32'(ucnt) >= CAPACITY)) begin
              dropped <= 1'b1;
              state   <= S_TOPRD;
            end else begin
              state <= S_DEC;
            end
          end
        end
        S_DEC: begin
          // tops from last result are in ltop/utop
          if (lcnt == '0 || samp <= ltop) begin
            if (lcnt > ucnt) begin
              // replace lower top with sample, push old top to upper
              heap <= 1'b0; val <= samp; pos <= '0; n <= (AW+1)'(lcnt);
              pend <= ltop; pend_heap <= 1'b1; pend_up <= 1'b1;
              ucnt <= ucnt + 1'b1;
              state <= S_DNL;
            end else begin
              heap <= 1'b0; val <= samp; pos <= (AW+1)'(lcnt);
              lcnt <= lcnt + 1'b1;
              state <= S_UPRD;
            end
          end else if (ucnt >= lcnt) begin
            if (ucnt == '0 || samp <= utop) begin
              heap <= 1'b0; val <= samp; pos <= (AW+1)'(lcnt);
              lcnt <= lcnt + 1'b1;
              state <= S_UPRD;
            end else begin
              heap <= 1'b1; val <= samp; pos <= '0; n <= (AW+1)'(ucnt);
              pend <= utop; pend_heap <= 1'b0; pend_up <= 1'b1;
              lcnt <= lcnt + 1'b1;
              state <= S_DNL;
            end
          end else begin
            heap <= 1'b1; val <= samp; pos <= (AW+1)'(ucnt);
            ucnt <= ucnt + 1'b1;
            state <= S_UPRD;
          end
        end
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (pos != '0 && above(heap, val, rd)) begin
            pos   <= par;
            state <= S_UPRD;
          end else begin
            state <= S_TOPRD;
          end
        end
        S_DNL: begin
          best  <= pos;
          bestv <= val;
          state <= S_DNR;
        end
        S_DNR: begin
          if (lch < n && above(heap, rd, val)) begin
            best  <= lch;
            bestv <= rd;
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (dn_next != pos) begin
            pos   <= dn_next;
            state <= S_DNL;
          end else if (pend_up) begin
            pend_up <= 1'b0;
            heap    <= pend_heap;
            val     <= pend;
            pos     <= pend_heap ? (AW+1)'(ucnt - 1'b1) : (AW+1)'(lcnt - 1'b1);
            state   <= S_UPRD;
          end else begin
            state <= S_TOPRD;
          end
        end
        S_TOPRD: state <= S_TOPW;
        S_TOPW: begin
          ltop  <= $signed(l_rd);
          utop  <= $signed(u_rd);
          state <= S_DONE;
        end
        S_DONE: begin
          // hold here while the previous result still waits
          if (out_load) begin
            out.overflow     <= dropped;
            out.stored_count <= 11'(32'(lcnt) + 32'(ucnt));
            out.median_valid <= (lcnt != '0);
            if (lcnt == '0) out.median_doubled <= '0;
            else if (lcnt == ucnt)
              out.median_doubled <= (SB+1)'(signed'({ltop[SB-1], ltop})
                                            + signed'({utop[SB-1], utop}));
            else
              out.median_doubled <= (SB+1)'(signed'({ltop, 1'b0}));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/rmth_checker.sv
//------------------------------------------------------------------------------
// rmth_checker
// Port-level checks on the running median block.
//------------------------------------------------------------------------------
`default_nettype none
module rmth_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire rmth_pkg::in_item_t  in,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire rmth_pkg::out_item_t out,
  input wire logic                out_valid,
  input wire logic                out_ready
);
  // hold result while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out)) else $error("result changed");
  // one item at a time: busy right after an intake
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
  // empty store means invalid median
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.stored_count == 0 |-> !out.median_valid) else $error("empty valid");
  // accept never yields result next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("result too early");
endmodule

bind running_median_two_heaps rmth_checker u_chk (.*);
`default_nettype wire

FILE: bench/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Checks the two-heap running median against a predictor that keeps its own
// sorted copy of the stored samples. Directed items cover empty, missing,
// restart, extreme values and a full store with drops; random items follow
// in bursts with gaps while the receiver stalls on its own pattern.
//------------------------------------------------------------------------------
`default_nettype none

class median_scoreboard;
  localparam int CAP = 1024;
  longint samples[$];              // stored samples kept in ascending order
  rmth_pkg::out_item_t pending[$];
  int mismatches;

  // Update the store and queue the result this item should produce.
  function void note_item(rmth_pkg::in_item_t it);
    rmth_pkg::out_item_t r;
    longint s;
    int n, pos;
    logic signed [32:0] twice;
    r = '0;
    if (it.restart) samples.delete();
    if (!it.sample_missing) begin
      if (samples.size() >= CAP) begin
        r.overflow = 1'b1;
      end else begin
        s = longint'(it.sample);
        pos = 0;
        while (pos < samples.size() && samples[pos] <= s) pos++;
        samples.insert(pos, s);
      end
    end
    n = samples.size();
    r.stored_count = 11'(n);
    if (n > 0) begin
      r.median_valid = 1'b1;
      // lower half holds the extra element on odd counts
      if (n % 2 == 1) twice = 33'(samples[n / 2] * 2);
      else twice = 33'(samples[n / 2 - 1] + samples[n / 2]);
      r.median_doubled = twice;
    end
    pending = {pending, r};
  endfunction

  // Compare one result with the oldest expectation.
  function void check_result(rmth_pkg::out_item_t got);
    rmth_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.median_doubled !== exp_r.median_doubled || got.median_valid !== exp_r.median_valid
        || got.stored_count !== exp_r.stored_count || got.overflow !== exp_r.overflow) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp med=%0d v=%0b n=%0d ovf=%0b got med=%0d v=%0b n=%0d ovf=%0b",
                 exp_r.median_doubled, exp_r.median_valid, exp_r.stored_count,
                 exp_r.overflow, got.median_doubled, got.median_valid,
                 got.stored_count, got.overflow);
    end
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rmth_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_item = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_item;
  logic out_valid;
  logic out_ready = 1'b0;
  int quiet = 0;
  median_scoreboard sb;

  running_median_two_heaps uut (
    .clk(clk), .rst(rst), .in(in_item), .in_valid(in_valid), .in_ready(in_ready),
    .out(out_item), .out_valid(out_valid), .out_ready(out_ready)
  );

  always #1 clk = ~clk;

  // Note accepted items, check results, watch for a hung block.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Stall the receiver: runs of ready, runs of stall, sometimes two ready runs in a row.
  initial begin
    int run;
    @(negedge clk);
    while (1) begin
      run = $urandom_range(1, 30);
      out_ready <= 1'b1;
      repeat (run) @(negedge clk);
      if ($urandom_range(0, 3) != 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  // Drive one item and hold it until it is accepted.
  task automatic send_item(input logic signed [31:0] s, input logic miss, input logic rs);
    in_item <= '{sample: s, sample_missing: miss, restart: rs};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample(input int spread);
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return 32'($signed($urandom_range(0, 2 * spread)) - spread);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int burst, sent, spread;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty, extremes, missing, restart with and without a sample.
    send_item(32'sd0, 1'b1, 1'b0);
    send_item(32'sh7fffffff, 1'b0, 1'b0);
    send_item(32'sh80000000, 1'b0, 1'b0);
    send_item(32'sh7fffffff, 1'b0, 1'b0);
    send_item(32'sh80000000, 1'b0, 1'b0);
    send_item(32'sd5, 1'b1, 1'b0);
    send_item(-32'sd1, 1'b0, 1'b0);
    send_item(32'sd1, 1'b0, 1'b0);
    send_item(32'sd0, 1'b0, 1'b0);
    send_item(32'sd3, 1'b1, 1'b1);
    send_item(32'sd42, 1'b0, 1'b1);
    send_item(32'sd42, 1'b0, 1'b0);
    send_item(32'sd7, 1'b0, 1'b0);
    send_item(32'sd100, 1'b0, 1'b0);
    send_item(32'sh55555555, 1'b0, 1'b0);
    send_item(32'shaaaaaaaa, 1'b0, 1'b0);

    // Hold off until every expected result has come.
    drain_results();

    // Fill the store past capacity to hit drops, then restart.
    send_item(32'sd9, 1'b0, 1'b1);
    for (int i = 0; i < 1030; i++) send_item(rand_sample(1000), 1'b0, 1'b0);
    send_item(32'sd1, 1'b1, 1'b0);
    send_item(32'sd0, 1'b0, 1'b1);

    // Random bursts with gaps; restarts keep the store mostly small.
    sent = 0;
    spread = 50;
    while (sent < 100) begin
      burst = $urandom_range(1, 25);
      for (int i = 0; i < burst; i++) begin
        if (sent % 25 == 0) spread = ($urandom_range(0, 1) != 0) ? 20 : 1000000;
        send_item(rand_sample(spread), $urandom_range(0, 9) == 0, $urandom_range(0, 59) == 0);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 15));
    end

    drain_results();
    repeat (100) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: files.f
src/rmth_pkg.sv
src/rmth_ram.sv
src/running_median_two_heaps.sv
src/rmth_checker.sv
bench/tb_top.sv
